[src/sic_pkg.sv]
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants
// Kind codes, default widths and the per-cell control word of the divider chain.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int OUT_BITS       = 40;
	localparam int KIND_BITS      = 3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE    = 3'd0,
		KIND_BOTH    = 3'd1,
		KIND_MINE    = 3'd2,
		KIND_OTHER   = 3'd3,
		KIND_OUTSIDE = 3'd4
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  neg_x;
		logic  neg_y;
	} cell_ctl_t;

endpackage

[src/sic_front.sv]
// ----------------------------------------------------------------------------
// sic_front: cross products, membership tests and dividend set-up
// Five stages that turn two segments into a positive divisor and two signed
// dividend magnitudes for the divider chain.
// ----------------------------------------------------------------------------
module sic_front #(
	parameter int C = 16,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [C-1:0]   p1x,
	input  logic signed [C-1:0]   p1y,
	input  logic signed [C-1:0]   p2x,
	input  logic signed [C-1:0]   p2y,
	input  logic signed [C-1:0]   o1x,
	input  logic signed [C-1:0]   o1y,
	input  logic signed [C-1:0]   o2x,
	input  logic signed [C-1:0]   o2y,
	output sic_pkg::cell_ctl_t    ctl,
	output logic [2*C:0]          den,
	output logic [3*C+1+F:0]      mag_x,
	output logic [3*C+1+F:0]      mag_y
);
	import sic_pkg::*;

	localparam int DFW = C + 1;
	localparam int SW  = 2 * C + 2;
	localparam int PW  = 3 * C + 4;
	localparam int AW  = 3 * C + 2;
	localparam int DW  = 2 * C + 1;

	// stage 1: differences and box offsets relative to O1
	logic                  v_s1;
	logic signed [DFW-1:0] dx_s1, dy_s1, ex_s1, ey_s1, ax_s1, ay_s1;
	logic signed [DFW-1:0] mlox_s1, mhix_s1, mloy_s1, mhiy_s1;
	logic signed [DFW-1:0] olox_s1, ohix_s1, oloy_s1, ohiy_s1;
	logic signed [C-1:0]   o1x_s1, o1y_s1;

	logic signed [DFW-1:0] p1x_e, p1y_e, p2x_e, p2y_e, o1x_e, o1y_e, o2x_e, o2y_e;
	logic signed [DFW-1:0] ex_c, ey_c;
	always_comb begin
		p1x_e = DFW'(p1x);
		p1y_e = DFW'(p1y);
		p2x_e = DFW'(p2x);
		p2y_e = DFW'(p2y);
		o1x_e = DFW'(o1x);
		o1y_e = DFW'(o1y);
		o2x_e = DFW'(o2x);
		o2y_e = DFW'(o2y);
		ex_c  = o2x_e - o1x_e;
		ey_c  = o2y_e - o1y_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= p2x_e - p1x_e;
			dy_s1   <= p2y_e - p1y_e;
			ex_s1   <= ex_c;
			ey_s1   <= ey_c;
			ax_s1   <= o1x_e - p1x_e;
			ay_s1   <= o1y_e - p1y_e;
			mlox_s1 <= ((p1x_e < p2x_e) ? p1x_e : p2x_e) - o1x_e;
			mhix_s1 <= ((p1x_e < p2x_e) ? p2x_e : p1x_e) - o1x_e;
			mloy_s1 <= ((p1y_e < p2y_e) ? p1y_e : p2y_e) - o1y_e;
			mhiy_s1 <= ((p1y_e < p2y_e) ? p2y_e : p1y_e) - o1y_e;
			olox_s1 <= (ex_c < 0) ? ex_c : '0;
			ohix_s1 <= (ex_c < 0) ? '0 : ex_c;
			oloy_s1 <= (ey_c < 0) ? ey_c : '0;
			ohiy_s1 <= (ey_c < 0) ? '0 : ey_c;
			o1x_s1  <= o1x;
			o1y_s1  <= o1y;
		end
	end

	// stage 2: numerator and denominator
	logic                  v_s2;
	logic signed [SW-1:0]  num_s2, den_s2;
	logic signed [DFW-1:0] ex_s2, ey_s2;
	logic signed [DFW-1:0] mlox_s2, mhix_s2, mloy_s2, mhiy_s2;
	logic signed [DFW-1:0] olox_s2, ohix_s2, oloy_s2, ohiy_s2;
	logic signed [C-1:0]   o1x_s2, o1y_s2;

	logic signed [SW:0] num_w, den_w;
	always_comb begin
		if (dy_s1 != 0) begin
			num_w = (SW+1)'(ax_s1) * (SW+1)'(dy_s1) - (SW+1)'(ay_s1) * (SW+1)'(dx_s1);
			den_w = (SW+1)'(ey_s1) * (SW+1)'(dx_s1) - (SW+1)'(ex_s1) * (SW+1)'(dy_s1);
		end else begin
			num_w = -(SW+1)'(ay_s1);
			den_w = (SW+1)'(ey_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= num_w[SW-1:0];
			den_s2  <= den_w[SW-1:0];
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;
			mlox_s2 <= mlox_s1;
			mhix_s2 <= mhix_s1;
			mloy_s2 <= mloy_s1;
			mhiy_s2 <= mhiy_s1;
			olox_s2 <= olox_s1;
			ohix_s2 <= ohix_s1;
			oloy_s2 <= oloy_s1;
			ohiy_s2 <= ohiy_s1;
			o1x_s2  <= o1x_s1;
			o1y_s2  <= o1y_s1;
		end
	end

	// stage 3: make the denominator positive
	logic                  v_s3, zero_s3;
	logic signed [SW-1:0]  num_s3, den_s3;
	logic signed [DFW-1:0] ex_s3, ey_s3;
	logic signed [DFW-1:0] mlox_s3, mhix_s3, mloy_s3, mhiy_s3;
	logic signed [DFW-1:0] olox_s3, ohix_s3, oloy_s3, ohiy_s3;
	logic signed [C-1:0]   o1x_s3, o1y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= (den_s2 == 0);
			num_s3  <= (den_s2 < 0) ? -num_s2 : num_s2;
			den_s3  <= (den_s2 < 0) ? -den_s2 : den_s2;
			ex_s3   <= ex_s2;
			ey_s3   <= ey_s2;
			mlox_s3 <= mlox_s2;
			mhix_s3 <= mhix_s2;
			mloy_s3 <= mloy_s2;
			mhiy_s3 <= mhiy_s2;
			olox_s3 <= olox_s2;
			ohix_s3 <= ohix_s2;
			oloy_s3 <= oloy_s2;
			ohiy_s3 <= ohiy_s2;
			o1x_s3  <= o1x_s2;
			o1y_s3  <= o1y_s2;
		end
	end

	// stage 4: scaled offsets and box bounds, all over the same denominator
	logic                 v_s4, zero_s4;
	logic signed [SW-1:0] den_s4;
	logic signed [PW-1:0] exn_s4, eyn_s4, bxd_s4, byd_s4;
	logic signed [PW-1:0] mlox_s4, mhix_s4, mloy_s4, mhiy_s4;
	logic signed [PW-1:0] olox_s4, ohix_s4, oloy_s4, ohiy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			den_s4  <= den_s3;
			exn_s4  <= PW'(ex_s3) * PW'(num_s3);
			eyn_s4  <= PW'(ey_s3) * PW'(num_s3);
			bxd_s4  <= PW'(o1x_s3) * PW'(den_s3);
			byd_s4  <= PW'(o1y_s3) * PW'(den_s3);
			mlox_s4 <= PW'(mlox_s3) * PW'(den_s3);
			mhix_s4 <= PW'(mhix_s3) * PW'(den_s3);
			mloy_s4 <= PW'(mloy_s3) * PW'(den_s3);
			mhiy_s4 <= PW'(mhiy_s3) * PW'(den_s3);
			olox_s4 <= PW'(olox_s3) * PW'(den_s3);
			ohix_s4 <= PW'(ohix_s3) * PW'(den_s3);
			oloy_s4 <= PW'(oloy_s3) * PW'(den_s3);
			ohiy_s4 <= PW'(ohiy_s3) * PW'(den_s3);
		end
	end

	// stage 5: classify, form dividend magnitudes and signs
	logic                 on_mine, on_other;
	logic signed [PW-1:0] sx, sy, ax_abs, ay_abs;
	kind_t                kind_c;
	always_comb begin
		on_mine  = (mlox_s4 <= exn_s4) && (exn_s4 <= mhix_s4) &&
			(mloy_s4 <= eyn_s4) && (eyn_s4 <= mhiy_s4);
		on_other = (olox_s4 <= exn_s4) && (exn_s4 <= ohix_s4) &&
			(oloy_s4 <= eyn_s4) && (eyn_s4 <= ohiy_s4);
		if (zero_s4) begin
			kind_c = KIND_NONE;
		end else if (on_mine) begin
			kind_c = on_other ? KIND_BOTH : KIND_MINE;
		end else begin
			kind_c = on_other ? KIND_OTHER : KIND_OUTSIDE;
		end
		sx     = bxd_s4 + exn_s4;
		sy     = byd_s4 + eyn_s4;
		ax_abs = (sx < 0) ? -sx : sx;
		ay_abs = (sy < 0) ? -sy : sy;
	end

	logic  v_s5, neg_x_s5, neg_y_s5;
	kind_t kind_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5  <= kind_c;
			neg_x_s5 <= (sx < 0);
			neg_y_s5 <= (sy < 0);
			den      <= den_s4[DW-1:0];
			mag_x    <= {ax_abs[AW-1:0], {F{1'b0}}};
			mag_y    <= {ay_abs[AW-1:0], {F{1'b0}}};
		end
	end

	assign ctl = '{valid: v_s5, kind: kind_s5, neg_x: neg_x_s5, neg_y: neg_y_s5};

endmodule

[src/sic_div_cell.sv]
// ----------------------------------------------------------------------------
// sic_div_cell: one restoring division step for both coordinates
// Shift one dividend bit into the partial remainder, subtract when it fits,
// and shift the quotient bit in behind the dividend.
// ----------------------------------------------------------------------------
module sic_div_cell #(
	parameter int DW = 33,
	parameter int MW = 66
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sic_pkg::cell_ctl_t ctl_i,
	input  logic [DW-1:0]      den_i,
	input  logic [DW-1:0]      rem_x_i,
	input  logic [MW-1:0]      mq_x_i,
	input  logic [DW-1:0]      rem_y_i,
	input  logic [MW-1:0]      mq_y_i,
	output sic_pkg::cell_ctl_t ctl_o,
	output logic [DW-1:0]      den_o,
	output logic [DW-1:0]      rem_x_o,
	output logic [MW-1:0]      mq_x_o,
	output logic [DW-1:0]      rem_y_o,
	output logic [MW-1:0]      mq_y_o
);
	import sic_pkg::*;

	logic [DW:0] tx, ty, sx, sy;
	logic        gx, gy;
	always_comb begin
		tx = {rem_x_i, mq_x_i[MW-1]};
		ty = {rem_y_i, mq_y_i[MW-1]};
		sx = tx - {1'b0, den_i};
		sy = ty - {1'b0, den_i};
		gx = (tx >= {1'b0, den_i});
		gy = (ty >= {1'b0, den_i});
	end

	logic  valid_q, neg_x_q, neg_y_q;
	kind_t kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q  <= ctl_i.kind;
			neg_x_q <= ctl_i.neg_x;
			neg_y_q <= ctl_i.neg_y;
			den_o   <= den_i;
			rem_x_o <= gx ? sx[DW-1:0] : tx[DW-1:0];
			rem_y_o <= gy ? sy[DW-1:0] : ty[DW-1:0];
			mq_x_o  <= {mq_x_i[MW-2:0], gx};
			mq_y_o  <= {mq_y_i[MW-2:0], gy};
		end
	end

	assign ctl_o = '{valid: valid_q, kind: kind_q, neg_x: neg_x_q, neg_y: neg_y_q};

endmodule

[src/segment_intersection_classifier.sv]
// Pipeline: five set-up stages, one divider cell per dividend bit and one
//   output register lie between input transfer and result.
// Throughput: one item per cycle while the output is not stalled; the divider
//   chain takes a new item each cycle unless a refused result holds the pipe.
// Reset: arst_n clears every valid flag at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_classifier: 2D segment crossing point and class
// Finds where the carrier lines of two segments meet, in Q.FRAC_BITS fixed
// point with truncating division and saturation, and says which segments
// hold the point.
// ----------------------------------------------------------------------------
module segment_intersection_classifier #(
	parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// from bit 0: mine_start_x, mine_start_y, mine_end_x, mine_end_y,
	// other_start_x, other_start_y, other_end_x, other_end_y (COORD_BITS each)
	input  logic [((8*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// from bit 0: cross_x, cross_y (40 bits each, signed)
	output logic [2*sic_pkg::OUT_BITS-1:0]       m_axis_tdata,
	// cross_kind
	output logic [sic_pkg::KIND_BITS-1:0]        m_axis_tuser
);
	import sic_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;            // positive divisor width
	localparam int MW = 3 * C + 2 + FRAC_BITS; // dividend width = cell count
	localparam int EW = ((MW > OUT_BITS) ? MW : OUT_BITS) + 1;

	localparam logic [EW-1:0] LIM_POS = (EW'(1) << (OUT_BITS - 1)) - EW'(1);
	localparam logic [EW-1:0] LIM_NEG = EW'(1) << (OUT_BITS - 1);

	// The whole pipe advances together; hold it only while a result waits
	// and the sink refuses it.
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Set-up stages
	cell_ctl_t     ctl_c   [0:MW];
	logic [DW-1:0] den_c   [0:MW];
	logic [DW-1:0] rem_x_c [0:MW];
	logic [MW-1:0] mq_x_c  [0:MW];
	logic [DW-1:0] rem_y_c [0:MW];
	logic [MW-1:0] mq_y_c  [0:MW];

	sic_front #(
		.C(C),
		.F(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.p1x      (s_axis_tdata[0*C +: C]),
		.p1y      (s_axis_tdata[1*C +: C]),
		.p2x      (s_axis_tdata[2*C +: C]),
		.p2y      (s_axis_tdata[3*C +: C]),
		.o1x      (s_axis_tdata[4*C +: C]),
		.o1y      (s_axis_tdata[5*C +: C]),
		.o2x      (s_axis_tdata[6*C +: C]),
		.o2y      (s_axis_tdata[7*C +: C]),
		.ctl      (ctl_c[0]),
		.den      (den_c[0]),
		.mag_x    (mq_x_c[0]),
		.mag_y    (mq_y_c[0])
	);

	// Partial remainders start empty at the head of the chain
	assign rem_x_c[0] = '0;
	assign rem_y_c[0] = '0;

	// Divider chain: one quotient bit per cell, MSB first
	for (genvar i = 0; i < MW; i++) begin : g_cell
		sic_div_cell #(
			.DW(DW),
			.MW(MW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_i   (ctl_c[i]),
			.den_i   (den_c[i]),
			.rem_x_i (rem_x_c[i]),
			.mq_x_i  (mq_x_c[i]),
			.rem_y_i (rem_y_c[i]),
			.mq_y_i  (mq_y_c[i]),
			.ctl_o   (ctl_c[i+1]),
			.den_o   (den_c[i+1]),
			.rem_x_o (rem_x_c[i+1]),
			.mq_x_o  (mq_x_c[i+1]),
			.rem_y_o (rem_y_c[i+1]),
			.mq_y_o  (mq_y_c[i+1])
		);
	end

	// Restore the sign and saturate to the output range; no crossing reads zero.
	logic [EW-1:0]       qx, qy, nx, ny;
	logic [OUT_BITS-1:0] rx, ry;
	always_comb begin
		qx = EW'(mq_x_c[MW]);
		qy = EW'(mq_y_c[MW]);
		nx = ~qx + EW'(1);
		ny = ~qy + EW'(1);
		if (ctl_c[MW].neg_x) begin
			rx = (qx > LIM_NEG) ? LIM_NEG[OUT_BITS-1:0] : nx[OUT_BITS-1:0];
		end else begin
			rx = (qx > LIM_POS) ? LIM_POS[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
		end
		if (ctl_c[MW].neg_y) begin
			ry = (qy > LIM_NEG) ? LIM_NEG[OUT_BITS-1:0] : ny[OUT_BITS-1:0];
		end else begin
			ry = (qy > LIM_POS) ? LIM_POS[OUT_BITS-1:0] : qy[OUT_BITS-1:0];
		end
		if (ctl_c[MW].kind == KIND_NONE) begin
			rx = '0;
			ry = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= ctl_c[MW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {ry, rx};
			m_axis_tuser <= ctl_c[MW].kind;
		end
	end

endmodule

[src/sic_checker.sv]
// ----------------------------------------------------------------------------
// sic_checker: port-level checks for the segment classifier
// Watch the stream ports over time and flag stall and result slips.
// ----------------------------------------------------------------------------
module sic_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [2*sic_pkg::OUT_BITS-1:0]   m_axis_tdata,
	input logic [sic_pkg::KIND_BITS-1:0]    m_axis_tuser
);
	import sic_pkg::*;

	// a refused result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no crossing carries a zero point
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_NONE) |-> (m_axis_tdata == '0))
		else $error("no-crossing result with non-zero point");

	// input side is open whenever the output register is free
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// input side closes while a result is refused
	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipe is held");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
